>>> sv/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg
// Types and constants shared by the frequency slot table controller, datapath
// and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fst_pkg;

  localparam logic [31:0] MIN_FREQ_HZ = 32'd100000000;
  localparam logic [15:0] MAX_BW_KHZ  = 16'd10000;
  localparam logic [7:0]  NO_SLOT     = 8'hFF;

  typedef enum logic [2:0] {
    CMD_ALLOC       = 3'd0,
    CMD_RELEASE     = 3'd1,
    CMD_READ        = 3'd2,
    CMD_SET_DIR     = 3'd3,
    CMD_RELEASE_ALL = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_ENABLED = 3'd1,
    ST_BAD_INDEX   = 3'd2,
    ST_SLOT_IDLE   = 3'd3,
    ST_BAD_FREQ    = 3'd4,
    ST_BAD_BW      = 3'd5,
    ST_FULL        = 3'd6,
    ST_PRESENT     = 3'd7
  } status_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_EXECUTE
  } state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic execute;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> sv/fst_ctrl.sv
// ----------------------------------------------------------------------------
// fst_ctrl
// Sequencer for one request: capture, compare against the table, execute.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fst_pkg::dp_status_t dp_status,
  output fst_pkg::dp_cmd_t       dp_cmd
);

  fst_pkg::state_t state_r;
  fst_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fst_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = fst_pkg::S_COMPARE;
        end
      end
      fst_pkg::S_COMPARE: begin
        state_nxt = fst_pkg::S_EXECUTE;
      end
      fst_pkg::S_EXECUTE: begin
        if (dp_status.out_free) begin
          state_nxt = fst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    dp_cmd.load     = 1'b0;
    dp_cmd.compare  = 1'b0;
    dp_cmd.execute  = 1'b0;
    case (state_r)
      fst_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        dp_cmd.load = in_valid;
      end
      fst_pkg::S_COMPARE: begin
        dp_cmd.compare = 1'b1;
      end
      fst_pkg::S_EXECUTE: begin
        dp_cmd.execute = dp_status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/fst_dp.sv
// ----------------------------------------------------------------------------
// fst_dp
// Slot storage, parallel frequency compare, lowest-index pick, command
// execution and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_dp #(
  parameter int SLOTS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fst_pkg::dp_cmd_t    dp_cmd,
  output fst_pkg::dp_status_t      dp_status,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic [2:0]          in_cmd,
  input  wire logic [31:0]         in_frequency,
  input  wire logic [15:0]         in_bandwidth,
  input  wire logic [7:0]          in_user,
  input  wire logic [7:0]          in_power,
  input  wire logic [7:0]          in_slot,
  input  wire logic                in_tx_enable,
  input  wire logic                in_rx_enable,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_status,
  output logic [7:0]               out_slot,
  output logic [31:0]              out_frequency,
  output logic [15:0]              out_bandwidth,
  output logic [7:0]               out_user,
  output logic [7:0]               out_power,
  output logic                     out_tx,
  output logic                     out_rx,
  output logic [7:0]               out_used_count
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // request latch
  logic [2:0]  req_cmd_r;
  logic [31:0] req_freq_r;
  logic [15:0] req_bw_r;
  logic [7:0]  req_user_r;
  logic [7:0]  req_power_r;
  logic [7:0]  req_slot_r;
  logic        req_tx_r;
  logic        req_rx_r;

  // table
  logic             enabled_r, enabled_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [1:0]       dir_r [SLOTS];
  logic [1:0]       dir_nxt [SLOTS];
  logic [31:0]      freq_r [SLOTS];
  logic [15:0]      bw_r [SLOTS];
  logic [7:0]       user_r [SLOTS];
  logic [7:0]       power_r [SLOTS];
  logic [7:0]       total_r, total_nxt;

  // compare stage
  logic [SLOTS-1:0] match_r;
  logic [SLOTS-1:0] free_r;

  // pick and execute
  logic             match_any, free_any;
  logic [IDX_W-1:0] match_idx, free_idx;
  logic             idx_ok;
  logic [IDX_W-1:0] sidx;
  logic             alloc_we;
  logic [2:0]       res_status;
  logic [7:0]       res_slot;
  logic [31:0]      res_freq;
  logic [15:0]      res_bw;
  logic [7:0]       res_user;
  logic [7:0]       res_power;
  logic             res_tx;
  logic             res_rx;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_slot_r;
  logic [31:0] out_freq_r;
  logic [15:0] out_bw_r;
  logic [7:0]  out_user_r;
  logic [7:0]  out_power_r;
  logic        out_tx_r;
  logic        out_rx_r;
  logic [7:0]  out_count_r;

  assign dp_status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      req_cmd_r   <= in_cmd;
      req_freq_r  <= in_frequency;
      req_bw_r    <= in_bandwidth;
      req_user_r  <= in_user;
      req_power_r <= in_power;
      req_slot_r  <= in_slot;
      req_tx_r    <= in_tx_enable;
      req_rx_r    <= in_rx_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.compare) begin
      for (int i = 0; i < SLOTS; i++) begin
        match_r[i] <= used_r[i] && (freq_r[i] == req_freq_r);
        free_r[i]  <= !used_r[i];
      end
    end
  end

  always_comb begin
    match_any = 1'b0;
    free_any  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (free_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign idx_ok = ({24'd0, req_slot_r} < 32'(SLOTS));
  assign sidx   = req_slot_r[IDX_W-1:0];

  always_comb begin
    enabled_nxt = enabled_r;
    used_nxt    = used_r;
    dir_nxt     = dir_r;
    total_nxt   = total_r;
    alloc_we    = 1'b0;
    res_status  = fst_pkg::ST_OK;
    res_slot    = fst_pkg::NO_SLOT;
    res_freq    = '0;
    res_bw      = '0;
    res_user    = '0;
    res_power   = '0;
    res_tx      = 1'b0;
    res_rx      = 1'b0;

    if (cfg_we) begin
      enabled_nxt = cfg_wdata;
      if (cfg_wdata && !enabled_r) begin
        used_nxt  = '0;
        total_nxt = '0;
        for (int i = 0; i < SLOTS; i++) begin
          dir_nxt[i] = 2'b00;
        end
      end
    end else if (dp_cmd.execute) begin
      if (!enabled_r) begin
        res_status = fst_pkg::ST_NOT_ENABLED;
      end else begin
        case (req_cmd_r)
          fst_pkg::CMD_ALLOC: begin
            if (req_freq_r < fst_pkg::MIN_FREQ_HZ) begin
              res_status = fst_pkg::ST_BAD_FREQ;
            end else if (req_bw_r == 16'd0 || req_bw_r > fst_pkg::MAX_BW_KHZ) begin
              res_status = fst_pkg::ST_BAD_BW;
            end else if (match_any) begin
              res_status = fst_pkg::ST_PRESENT;
              res_slot   = 8'(match_idx);
            end else if (free_any) begin
              alloc_we           = 1'b1;
              used_nxt[free_idx] = 1'b1;
              dir_nxt[free_idx]  = 2'b11;
              total_nxt          = total_r + 8'd1;
              res_slot           = 8'(free_idx);
            end else begin
              res_status = fst_pkg::ST_FULL;
            end
          end
          fst_pkg::CMD_RELEASE: begin
            if (!idx_ok) begin
              res_status = fst_pkg::ST_BAD_INDEX;
            end else if (used_r[sidx]) begin
              used_nxt[sidx] = 1'b0;
              dir_nxt[sidx]  = 2'b00;
              total_nxt      = total_r - 8'd1;
            end
          end
          fst_pkg::CMD_READ: begin
            if (!idx_ok) begin
              res_status = fst_pkg::ST_BAD_INDEX;
            end else if (!used_r[sidx]) begin
              res_status = fst_pkg::ST_SLOT_IDLE;
            end else begin
              res_slot  = req_slot_r;
              res_freq  = freq_r[sidx];
              res_bw    = bw_r[sidx];
              res_user  = user_r[sidx];
              res_power = power_r[sidx];
              res_tx    = dir_r[sidx][0];
              res_rx    = dir_r[sidx][1];
            end
          end
          fst_pkg::CMD_SET_DIR: begin
            if (!idx_ok) begin
              res_status = fst_pkg::ST_BAD_INDEX;
            end else if (!used_r[sidx]) begin
              res_status = fst_pkg::ST_SLOT_IDLE;
            end else begin
              dir_nxt[sidx] = {req_rx_r, req_tx_r};
            end
          end
          fst_pkg::CMD_RELEASE_ALL: begin
            used_nxt  = '0;
            total_nxt = '0;
            for (int i = 0; i < SLOTS; i++) begin
              dir_nxt[i] = 2'b00;
            end
          end
          default: begin
            res_status = fst_pkg::ST_BAD_INDEX;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      used_r    <= '0;
      total_r   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        dir_r[i] <= 2'b00;
      end
    end else begin
      enabled_r <= enabled_nxt;
      used_r    <= used_nxt;
      total_r   <= total_nxt;
      dir_r     <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_we) begin
      freq_r[free_idx]  <= req_freq_r;
      bw_r[free_idx]    <= req_bw_r;
      user_r[free_idx]  <= req_user_r;
      power_r[free_idx] <= req_power_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_freq_r   <= res_freq;
      out_bw_r     <= res_bw;
      out_user_r   <= res_user;
      out_power_r  <= res_power;
      out_tx_r     <= res_tx;
      out_rx_r     <= res_rx;
      out_count_r  <= total_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_frequency  = out_freq_r;
  assign out_bandwidth  = out_bw_r;
  assign out_user       = out_user_r;
  assign out_power      = out_power_r;
  assign out_tx         = out_tx_r;
  assign out_rx         = out_rx_r;
  assign out_used_count = out_count_r;

endmodule

`default_nettype wire

>>> sv/frequency_slot_table.sv
// ----------------------------------------------------------------------------
// frequency_slot_table
// Table of SLOTS frequency slots with allocate (duplicate check, lowest free
// slot), release, read, set direction and release all.
// ----------------------------------------------------------------------------
// A request passes through three steps: accept, a parallel compare of the
// requested frequency against every used slot, then a lowest-index pick and
// table update that loads the result register. The next request is accepted as
// soon as the previous one has loaded the result register; it waits in the
// execute step only while an earlier result is still held by out_ready low.
// The table must be enabled through cfg_we/cfg_wdata before use; a write
// that turns it on frees every slot. Entry contents are undefined until a
// slot is allocated.
`default_nettype none

module frequency_slot_table #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [31:0] in_frequency,
  input  wire logic [15:0] in_bandwidth,
  input  wire logic [7:0]  in_user,
  input  wire logic [7:0]  in_power,
  input  wire logic [7:0]  in_slot,
  input  wire logic        in_tx_enable,
  input  wire logic        in_rx_enable,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot,
  output logic [31:0]      out_frequency,
  output logic [15:0]      out_bandwidth,
  output logic [7:0]       out_user,
  output logic [7:0]       out_power,
  output logic             out_tx,
  output logic             out_rx,
  output logic [7:0]       out_used_count
);

  fst_pkg::dp_cmd_t    dp_cmd;
  fst_pkg::dp_status_t dp_status;

  fst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  fst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .dp_status      (dp_status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (in_cmd),
    .in_frequency   (in_frequency),
    .in_bandwidth   (in_bandwidth),
    .in_user        (in_user),
    .in_power       (in_power),
    .in_slot        (in_slot),
    .in_tx_enable   (in_tx_enable),
    .in_rx_enable   (in_rx_enable),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_frequency  (out_frequency),
    .out_bandwidth  (out_bandwidth),
    .out_user       (out_user),
    .out_power      (out_power),
    .out_tx         (out_tx),
    .out_rx         (out_rx),
    .out_used_count (out_used_count)
  );

endmodule

`default_nettype wire
